/* rtl/core/lfir_pkg.sv */
`default_nettype none

package lfir_pkg;

   // kernel length and memory address width
   localparam int TAPS       = 1024;
   localparam int TAP_ADDR_W = $clog2(TAPS);

   // field widths
   localparam int TAP_IDX_W = 10;
   localparam int SAMPLE_W  = 16;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int ACC_W     = 48;
   localparam int FRAC_W    = 15;

   // width wide enough to compare a tap index against TAPS itself
   localparam int TAP_CMP_W = ((TAP_IDX_W > TAP_ADDR_W) ? TAP_IDX_W : TAP_ADDR_W) + 1;

   // last memory address
   localparam logic [TAP_ADDR_W-1:0] TAP_LAST = TAP_ADDR_W'(TAPS - 1);

   // item mode codes
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   // saturation limits, output and accumulator scale
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_SAT_MAX = ACC_W'((2 ** (SAMPLE_W-1)) - 1);
   localparam logic signed [ACC_W-1:0] ACC_SAT_MIN = ACC_W'(-(2 ** (SAMPLE_W-1)));

   // sequencer to multiply-accumulate
   typedef struct packed {
      logic start;
      logic vld;
      logic last;
   } lfir_mac_ctl_type;

   // multiply-accumulate result
   typedef struct packed {
      logic                res_vld;
      logic [SAMPLE_W-1:0] filtered;
      logic                clipped;
   } lfir_mac_sts_type;

endpackage

`default_nettype wire

/* rtl/core/long_kernel_fir_convolution_core.sv */
`default_nettype none

// channel | ports                                              | direction
// req     | req_valid/ready, mode, tap_index, tap_value,       | in
//         | sample_value                                       |
// rsp     | rsp_valid/ready, filtered, clipped                 | out
//
// A load item is written into the kernel memory as it is accepted. A sample
// item keeps the core busy until its result moves into the output register:
// one shared multiply-accumulate walks every kernel tap, one read of each
// memory per cycle, then a short pipeline drain. After reset a clearing pass
// zeroes both memories; no item is accepted until it ends. A stalled rsp side
// holds a finished result while further items are taken; a later sample
// result then waits in the drain until the held one is taken.

module long_kernel_fir_convolution_core
   import lfir_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_mode,
   input  wire logic [TAP_IDX_W-1:0] req_tap_index,
   input  wire logic [SAMPLE_W-1:0]  req_tap_value,
   input  wire logic [SAMPLE_W-1:0]  req_sample_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [SAMPLE_W-1:0]  rsp_filtered,
   output logic                      rsp_clipped
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [TAP_ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [TAP_ADDR_W-1:0]   pos_ff, pos_in;
   logic [TAP_ADDR_W-1:0]   idx_ff, idx_in;
   logic                    d1_vld_ff, d1_last_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_filtered_ff;
   logic                    rsp_clipped_ff;

   logic                    cnt_last;
   logic [TAP_ADDR_W-1:0]   pos_next, idx_prev;
   logic [TAP_CMP_W-1:0]    tap_ext;
   logic                    tap_ok;
   logic                    issue, rsp_load;

   logic                    kw_en, hw_en;
   logic [TAP_ADDR_W-1:0]   kw_addr, hw_addr;
   logic [SAMPLE_W-1:0]     kw_data, hw_data;
   logic [SAMPLE_W-1:0]     k_rd, h_rd;

   lfir_mac_ctl_type        mac_ctl;
   lfir_mac_sts_type        mac_sts;

   // address arithmetic
   assign cnt_last = cnt_ff == TAP_LAST;
   assign pos_next = (pos_ff == TAP_LAST) ? '0 : TAP_ADDR_W'(pos_ff + 1'b1);
   assign idx_prev = (idx_ff == '0) ? TAP_LAST : TAP_ADDR_W'(idx_ff - 1'b1);
   assign tap_ext  = TAP_CMP_W'(req_tap_index);
   assign tap_ok   = tap_ext < TAP_CMP_W'(TAPS);

   assign req_ready = state_ff == ST_IDLE;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      kw_en    = 1'b0;
      kw_addr  = cnt_ff;
      kw_data  = '0;
      hw_en    = 1'b0;
      hw_addr  = cnt_ff;
      hw_data  = '0;
      issue    = 1'b0;
      rsp_load = 1'b0;
      mac_ctl.start = 1'b0;
      mac_ctl.vld   = d1_vld_ff;
      mac_ctl.last  = d1_last_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            kw_en  = 1'b1;
            hw_en  = 1'b1;
            cnt_in = TAP_ADDR_W'(cnt_ff + 1'b1);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  kw_en   = tap_ok;
                  kw_addr = TAP_ADDR_W'(req_tap_index);
                  kw_data = req_tap_value;
               end else begin
                  hw_en         = 1'b1;
                  hw_addr       = pos_next;
                  hw_data       = req_sample_value;
                  pos_in        = pos_next;
                  idx_in        = pos_next;
                  cnt_in        = '0;
                  mac_ctl.start = 1'b1;
                  state_in      = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            issue  = 1'b1;
            idx_in = idx_prev;
            cnt_in = TAP_ADDR_W'(cnt_ff + 1'b1);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_sts.res_vld && (!rsp_valid_ff || rsp_ready)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // output slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         d1_vld_ff    <= 1'b0;
         d1_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         d1_vld_ff    <= issue;
         d1_last_ff   <= issue & cnt_last;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff <= mac_sts.filtered;
         rsp_clipped_ff  <= mac_sts.clipped;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_clipped  = rsp_clipped_ff;

   // kernel tap store
   lfir_ram #(
      .Depth (TAPS),
      .Width (SAMPLE_W)
   ) u_kernel_ram (
      .clock   (clock),
      .wr_en   (kw_en),
      .wr_addr (kw_addr),
      .wr_data (kw_data),
      .rd_addr (cnt_ff),
      .rd_data (k_rd)
   );

   // sample delay line
   lfir_ram #(
      .Depth (TAPS),
      .Width (SAMPLE_W)
   ) u_history_ram (
      .clock   (clock),
      .wr_en   (hw_en),
      .wr_addr (hw_addr),
      .wr_data (hw_data),
      .rd_addr (idx_ff),
      .rd_data (h_rd)
   );

   // shared multiply-accumulate
   lfir_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .tap    (k_rd),
      .sample (h_rd),
      .sts    (mac_sts)
   );

endmodule

`default_nettype wire

/* rtl/core/lfir_ram.sv */
`default_nettype none

module lfir_ram #(
   parameter  int Depth = 1024,
   parameter  int Width = 16,
   localparam int AddrW = $clog2(Depth)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/lfir_mac.sv */
`default_nettype none

module lfir_mac
   import lfir_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lfir_mac_ctl_type    ctl,
   input  wire logic [SAMPLE_W-1:0] tap,
   input  wire logic [SAMPLE_W-1:0] sample,
   output lfir_mac_sts_type         sts
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     p_vld_ff, p_last_ff;
   logic                     res_vld_ff, res_vld_in;
   logic signed [ACC_W-1:0]  quot;
   logic                     clip_hi, clip_lo;

   // product stage
   assign prod_in = $signed(tap) * $signed(sample);

   // accumulate stage, cleared when a new sample item starts
   always_comb begin
      acc_in     = acc_ff;
      res_vld_in = res_vld_ff;
      if (ctl.start) begin
         acc_in     = '0;
         res_vld_in = 1'b0;
      end else if (p_vld_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         if (p_last_ff) begin
            res_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff   <= 1'b0;
         p_last_ff  <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         p_vld_ff   <= ctl.vld;
         p_last_ff  <= ctl.last;
         res_vld_ff <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // floor shift and saturation of the finished sum
   assign quot    = acc_ff >>> FRAC_W;
   assign clip_hi = quot > ACC_SAT_MAX;
   assign clip_lo = quot < ACC_SAT_MIN;

   always_comb begin
      sts.res_vld = res_vld_ff;
      sts.clipped = clip_hi | clip_lo;
      if (clip_hi) begin
         sts.filtered = SAMPLE_MAX;
      end else if (clip_lo) begin
         sts.filtered = SAMPLE_MIN;
      end else begin
         sts.filtered = quot[SAMPLE_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
   import lfir_pkg::*;

   // quiet cycles before the run is declared hung; covers the clearing pass,
   // one full kernel walk and the longest stall on either side
   localparam int HANG_LIMIT   = 8 * TAPS;
   localparam int DRAIN_CYCLES = TAPS + 32;
   localparam int RANDOM_ITEMS = 470;
   localparam int DENSE_TAPS   = 48;

   typedef struct packed {
      logic [SAMPLE_W-1:0] filtered;
      logic                clipped;
   } fir_out_t;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_mode         = MODE_LOAD;
   logic [TAP_IDX_W-1:0] req_tap_index    = '0;
   logic [SAMPLE_W-1:0]  req_tap_value    = '0;
   logic [SAMPLE_W-1:0]  req_sample_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_filtered;
   logic                 rsp_clipped;

   // filter state as the testbench sees it
   logic signed [SAMPLE_W-1:0] kernel_copy  [TAPS] = '{default: '0};
   logic signed [SAMPLE_W-1:0] history_copy [TAPS] = '{default: '0};
   int unsigned newest_slot    = 0;

   fir_out_t pending_outputs[$];
   int       fail_count   = 0;
   int       quiet_cycles = 0;
   int       ready_hold   = 0;
   bit       steady_flow  = 1'b0;

   long_kernel_fir_convolution_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_tap_index    (req_tap_index),
      .req_tap_value    (req_tap_value),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filtered     (rsp_filtered),
      .rsp_clipped      (rsp_clipped)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // idle length: mostly none or short, now and then long
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      if (roll < 98) return $urandom_range(5, 16);
      return $urandom_range(30, 90);
   endfunction

   // Q1.15 word: extremes, small magnitudes or anything
   function automatic logic [SAMPLE_W-1:0] random_word();
      int          roll;
      logic [31:0] r;
      roll = $urandom_range(0, 9);
      r    = $urandom;
      if (roll == 0) return SAMPLE_MAX;
      if (roll == 1) return SAMPLE_MIN;
      if (roll < 4) return {{(SAMPLE_W-8){r[7]}}, r[7:0]};
      return r[SAMPLE_W-1:0];
   endfunction

   // tap position: half at the head of the kernel, some at its far end, the rest anywhere
   function automatic logic [TAP_IDX_W-1:0] random_index();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return TAP_IDX_W'($urandom_range(0, 15));
      if (roll < 70) return TAP_IDX_W'($urandom_range(TAPS - 16, TAPS - 1));
      return TAP_IDX_W'($urandom_range(0, TAPS - 1));
   endfunction

   // push one sample into the delay line and work out y[n], floored and saturated
   function automatic fir_out_t convolve_sample(input logic [SAMPLE_W-1:0] sample);
      longint      acc;
      longint      scaled;
      int unsigned slot;
      int          j;
      fir_out_t    res;
      newest_slot = (newest_slot + 1 >= TAPS) ? 0 : newest_slot + 1;
      history_copy[newest_slot] = sample;
      slot = newest_slot;
      acc  = 0;
      for (j = 0; j < TAPS; j++) begin
         acc += longint'(kernel_copy[j]) * longint'(history_copy[slot]);
         slot = (slot == 0) ? TAPS - 1 : slot - 1;
      end
      scaled = acc >>> FRAC_W;
      if (scaled > 32767) begin
         res.filtered = SAMPLE_MAX;
         res.clipped  = 1'b1;
      end else if (scaled < -32768) begin
         res.filtered = SAMPLE_MIN;
         res.clipped  = 1'b1;
      end else begin
         res.filtered = SAMPLE_W'(scaled);
         res.clipped  = 1'b0;
      end
      return res;
   endfunction

   // present one item, hold it until taken, then update the expected state
   task automatic send_item(input logic mode, input logic [TAP_IDX_W-1:0] index,
                            input logic [SAMPLE_W-1:0] tap,
                            input logic [SAMPLE_W-1:0] sample);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_tap_index    <= index;
      req_tap_value    <= tap;
      req_sample_value <= sample;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (mode == MODE_LOAD) begin
         if (int'(index) < TAPS) kernel_copy[index] = tap;
      end else begin
         pending_outputs.push_back(convolve_sample(sample));
      end
   endtask

   // the field a load or sample ignores is filled with noise
   task automatic load_tap(input int index, input logic [SAMPLE_W-1:0] value);
      send_item(MODE_LOAD, TAP_IDX_W'(index), value, SAMPLE_W'($urandom));
   endtask

   task automatic push_sample(input logic [SAMPLE_W-1:0] value);
      send_item(MODE_SAMPLE, TAP_IDX_W'($urandom), SAMPLE_W'($urandom), value);
   endtask

   // empty kernel after reset: every output is zero
   task automatic test_zero_kernel();
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample('0);
   endtask

   // extreme taps at both ends of the kernel
   task automatic test_tap_extremes();
      load_tap(0, SAMPLE_MAX);
      push_sample(SAMPLE_MAX);
      load_tap(TAPS - 1, SAMPLE_MIN);
      push_sample(SAMPLE_MIN);
   endtask

   // clipping both ways, a single-product overflow and floor rounding
   task automatic test_saturation_and_rounding();
      load_tap(0, SAMPLE_MIN);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      load_tap(1, SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      load_tap(0, 16'sd1);
      load_tap(1, '0);
      push_sample(-16'sd1);
      push_sample(16'sd1);
   endtask

   // mixed loads and samples, with one stretch free of idling
   task automatic test_random_traffic();
      int n;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady_flow = (n >= 200 && n < 260);
         if ($urandom_range(0, 99) < 35) load_tap(random_index(), random_word());
         else push_sample(random_word());
      end
      steady_flow = 1'b0;
   endtask

   // small taps spread across the whole kernel, then a run of samples
   task automatic test_dense_kernel();
      int n;
      for (n = 0; n < DENSE_TAPS; n++) begin
         load_tap(n * (TAPS / DENSE_TAPS), SAMPLE_W'($urandom_range(0, 255) - 128));
      end
      repeat (DENSE_TAPS) push_sample(random_word());
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready  <= steady_flow || ($urandom_range(0, 9) < 7);
         ready_hold <= gap_length();
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      fir_out_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_outputs.size() == 0) begin
            $error("result with nothing expected: filtered %0d clipped %0b",
                   $signed(rsp_filtered), rsp_clipped);
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_filtered !== want.filtered) begin
               $error("filtered: expected %0d, got %0d",
                      $signed(want.filtered), $signed(rsp_filtered));
               fail_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("clipped: expected %0b, got %0b", want.clipped, rsp_clipped);
               fail_count++;
            end
         end
      end
   end

   // hang detection
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == HANG_LIMIT) begin
         $error("no handshake for %0d cycles, %0d results outstanding",
                HANG_LIMIT, pending_outputs.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_zero_kernel();
      test_tap_extremes();
      test_saturation_and_rounding();
      test_random_traffic();
      test_dense_kernel();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/lfir_pkg.sv
rtl/core/lfir_ram.sv
rtl/core/lfir_mac.sv
rtl/core/long_kernel_fir_convolution_core.sv
tb/tb.sv
